[rtl/ltdc_pkg.sv]
// Shared types and constants of the link timing diagnostics collector.
// Holds the configuration, command, record and result structures.
// Depends on nothing; every other file but ltdc_ram imports it.
`timescale 1ns / 1ps

package ltdc_pkg;

  localparam int unsigned MAX_CONN     = 16;
  localparam int unsigned CONN_W       = $clog2(MAX_CONN);
  localparam int unsigned BIN_COUNT    = 5;
  localparam int unsigned EDGE_COUNT   = 4;
  localparam int unsigned ERR_KINDS    = 5;
  localparam int unsigned REPORT_WORDS = ERR_KINDS + 2 * BIN_COUNT;
  localparam logic [3:0]  LAST_WORD    = 4'(REPORT_WORDS - 1);
  localparam logic [3:0]  FIRST_DLY    = 4'(ERR_KINDS);
  localparam logic [3:0]  FIRST_ALV    = 4'(ERR_KINDS + BIN_COUNT);

  typedef enum logic [2:0] {
    ACT_TIMING = 3'd0,
    ACT_SAFETY = 3'd1,
    ACT_ADDR   = 3'd2,
    ACT_TYPE   = 3'd3,
    ACT_SN     = 3'd4,
    ACT_CSN    = 3'd5,
    ACT_SEND   = 3'd6,
    ACT_CLEAR  = 3'd7
  } action_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_CONN  = 2'd1,
    ST_LATE      = 2'd2,
    ST_BAD_EDGES = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    REG_NUM_CONN = 3'd0,
    REG_MAX_AGE  = 3'd1,
    REG_WINDOW   = 3'd2,
    REG_EDGE_1   = 3'd3,
    REG_EDGE_2   = 3'd4,
    REG_EDGE_3   = 3'd5,
    REG_EDGE_4   = 3'd6
  } reg_idx_e;

  // Work the back end has to do for one request.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_UPDATE,
    OP_ERROR,
    OP_REPORT,
    OP_CLEAR
  } op_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EXEC,
    BK_REPORT
  } back_state_e;

  typedef struct packed {
    logic [4:0]                 num_conn;
    logic [15:0]                max_age;
    logic [15:0]                window;
    logic [EDGE_COUNT-1:0][15:0] bin_edge;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    status_e          status;
    logic [CONN_W-1:0] conn;
    logic [2:0]       err_sel;
    logic [2:0]       dly_bin;
    logic [2:0]       alv_bin;
  } cmd_t;

  typedef struct packed {
    logic [15:0]                 msg_cnt;
    logic [ERR_KINDS-1:0][31:0]  err;
    logic [BIN_COUNT-1:0][15:0]  dly;
    logic [BIN_COUNT-1:0][15:0]  alv;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

  typedef struct packed {
    logic [CONN_W-1:0] conn;
    status_e          status;
    logic             is_word;
    logic [3:0]       idx;
    logic [31:0]      value;
    logic             last;
  } res_t;

endpackage

[rtl/link_timing_diagnostics_collector.sv]
// A request is held in the command queue; the back end then reads its record
// through the registered RAM port in the idle state; the execute state writes
// any updated record and any status result; a new command waits until then.
// Report words leave one per cycle while the result queue has room.
// Reset: configuration returns to its defaults and all connection records
// read as zero at once through per-connection valid bits; no clearing pass.
`timescale 1ns / 1ps

// Top level of the link timing diagnostics collector. It holds the
// configuration registers and ties the front end (checking, binning and a
// command queue) to the back end (record read-modify-write and reporting).
// Each request produces either one status result or fifteen report words,
// the last of which carries the last flag. Depends on ltdc_pkg, ltdc_front
// and ltdc_back.
module link_timing_diagnostics_collector
  import ltdc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Request side
  input  logic              push,
  output logic              full,
  input  logic [2:0]        action_i,
  input  logic [CONN_W-1:0] connection_i,
  input  logic [15:0]       round_trip_delay_i,
  input  logic [15:0]       alive_time_i,
  // Result side
  output logic              empty,
  input  logic              pop,
  output logic [CONN_W-1:0] report_connection_o,
  output logic [1:0]        status_o,
  output logic              is_report_word_o,
  output logic [3:0]        word_index_o,
  output logic [31:0]       word_value_o,
  output logic              last_o,
  // Configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [15:0]       cfg_data_i
);

  cfg_t cfg_q;
  logic cmd_valid, cmd_pop;
  cmd_t cmd;
  res_t res;

  // Configuration writes are always taken; the user must issue them only when
  // idle, so the front end sees stable settings; the block does not enforce it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_conn    <= 5'd1;
      cfg_q.max_age     <= 16'd750;
      cfg_q.window      <= 16'd5000;
      cfg_q.bin_edge[0] <= 16'd150;
      cfg_q.bin_edge[1] <= 16'd300;
      cfg_q.bin_edge[2] <= 16'd450;
      cfg_q.bin_edge[3] <= 16'd600;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_NUM_CONN: cfg_q.num_conn    <= cfg_data_i[4:0];
        REG_MAX_AGE:  cfg_q.max_age     <= cfg_data_i;
        REG_WINDOW:   cfg_q.window      <= cfg_data_i;
        REG_EDGE_1:   cfg_q.bin_edge[0] <= cfg_data_i;
        REG_EDGE_2:   cfg_q.bin_edge[1] <= cfg_data_i;
        REG_EDGE_3:   cfg_q.bin_edge[2] <= cfg_data_i;
        REG_EDGE_4:   cfg_q.bin_edge[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The front end resolves every error status up front, so the back end only
  // writes the record RAM for requests that really change state.
  ltdc_front u_front (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg_q),
    .push_i             (push),
    .full_o             (full),
    .action_i           (action_i),
    .connection_i       (connection_i),
    .round_trip_delay_i (round_trip_delay_i),
    .alive_time_i       (alive_time_i),
    .cmd_valid_o        (cmd_valid),
    .cmd_o              (cmd),
    .cmd_pop_i          (cmd_pop)
  );

  // The back end owns the record RAM and the result queue; a stalled result
  // side holds the back end only; the command queue takes requests until full.
  ltdc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .window_i    (cfg_q.window),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_o       (res),
    .res_empty_o (empty),
    .res_pop_i   (pop)
  );

  assign report_connection_o = res.conn;
  assign status_o            = res.status;
  assign is_report_word_o    = res.is_word;
  assign word_index_o        = res.idx;
  assign word_value_o        = res.value;
  assign last_o              = res.last;

endmodule

[rtl/ltdc_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module ltdc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/ltdc_front.sv]
// Front end: checks and classifies incoming requests, sorts times into bins,
// and queues the resulting commands for the back end. Uses ltdc_pkg.
`timescale 1ns / 1ps

module ltdc_front
  import ltdc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  logic              push_i,
  output logic              full_o,
  input  logic [2:0]        action_i,
  input  logic [CONN_W-1:0] connection_i,
  input  logic [15:0]       round_trip_delay_i,
  input  logic [15:0]       alive_time_i,
  output logic              cmd_valid_o,
  output cmd_t              cmd_o,
  input  logic              cmd_pop_i
);

  function automatic logic [2:0] bin_of(input logic [15:0] t,
                                        input logic [EDGE_COUNT-1:0][15:0] e);
    logic [2:0] b;
    b = 3'(EDGE_COUNT);
    for (int i = EDGE_COUNT - 1; i >= 0; i--) begin
      if (t <= e[i]) b = 3'(i);
    end
    return b;
  endfunction

  cmd_t cmd_in;
  logic edges_ok;
  logic late;

  always_comb begin
    edges_ok = (cfg_i.bin_edge[0] != 16'd0)
            && (cfg_i.bin_edge[0] < cfg_i.bin_edge[1])
            && (cfg_i.bin_edge[1] < cfg_i.bin_edge[2])
            && (cfg_i.bin_edge[2] < cfg_i.bin_edge[3])
            && (cfg_i.bin_edge[3] < cfg_i.max_age);
    late = (round_trip_delay_i > cfg_i.max_age) || (alive_time_i > cfg_i.max_age);

    cmd_in         = '0;
    cmd_in.op      = OP_NONE;
    cmd_in.status  = ST_OK;
    cmd_in.conn    = connection_i;
    cmd_in.dly_bin = bin_of(round_trip_delay_i, cfg_i.bin_edge);
    cmd_in.alv_bin = bin_of(alive_time_i, cfg_i.bin_edge);
    cmd_in.err_sel = 3'(action_i - 3'd1);

    if ({1'b0, connection_i} >= cfg_i.num_conn) begin
      cmd_in.status = ST_BAD_CONN;
    end else begin
      unique case (action_e'(action_i)) inside
        ACT_TIMING: begin
          if (!edges_ok) begin
            cmd_in.status = ST_BAD_EDGES;
          end else if (late) begin
            cmd_in.status = ST_LATE;
          end else begin
            cmd_in.op = OP_UPDATE;
          end
        end
        ACT_SAFETY, ACT_ADDR, ACT_TYPE, ACT_SN, ACT_CSN: cmd_in.op = OP_ERROR;
        ACT_SEND:  cmd_in.op = OP_REPORT;
        ACT_CLEAR: cmd_in.op = OP_CLEAR;
        default:   cmd_in.op = OP_NONE;
      endcase
    end
  end

  // Two-entry command queue.
  cmd_t       q_mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem_q[rd_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && cmd_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem_q[wr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
      cnt_q <= 2'(cnt_q + {1'b0, do_push} - {1'b0, do_pop});
    end
  end

endmodule

[rtl/ltdc_back.sv]
// Back end: read-modify-write of one connection record held in ltdc_ram,
// report word sequencing, and a two-entry result queue. Uses ltdc_pkg.
`timescale 1ns / 1ps

module ltdc_back
  import ltdc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] window_i,
  input  logic        cmd_valid_i,
  input  cmd_t        cmd_i,
  output logic        cmd_pop_o,
  output res_t        res_o,
  output logic        res_empty_o,
  input  logic        res_pop_i
);

  back_state_e       state_q, state_d;
  cmd_t              cmd_q;
  logic              rd_valid_q;
  logic [MAX_CONN-1:0] valid_q;
  rec_t              rep_q;
  logic [3:0]        word_q;

  logic              ram_re, ram_we;
  logic [REC_W-1:0]  ram_rdata;
  rec_t              rec_cur, rec_upd;
  logic              hit_window;
  logic              res_full, res_push;
  res_t              res_item;
  logic              valid_set, valid_clr, rep_load, word_inc;

  ltdc_ram #(
    .WIDTH (REC_W),
    .DEPTH (MAX_CONN)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cmd_q.conn),
    .wdata_i (rec_upd),
    .re_i    (ram_re),
    .raddr_i (cmd_i.conn),
    .rdata_o (ram_rdata)
  );

  // A record never written since reset or since its last clear or report reads as zero.
  always_comb begin
    rec_cur = rd_valid_q ? rec_t'(ram_rdata) : '0;
    rec_upd = rec_cur;
    if (cmd_q.op == OP_ERROR) begin
      if (rec_upd.err[cmd_q.err_sel] != '1) begin
        rec_upd.err[cmd_q.err_sel] = rec_upd.err[cmd_q.err_sel] + 32'd1;
      end
    end else begin
      if (rec_upd.dly[cmd_q.dly_bin] != '1) begin
        rec_upd.dly[cmd_q.dly_bin] = rec_upd.dly[cmd_q.dly_bin] + 16'd1;
      end
      if (rec_upd.alv[cmd_q.alv_bin] != '1) begin
        rec_upd.alv[cmd_q.alv_bin] = rec_upd.alv[cmd_q.alv_bin] + 16'd1;
      end
      if (rec_upd.msg_cnt != '1) begin
        rec_upd.msg_cnt = rec_upd.msg_cnt + 16'd1;
      end
    end
    hit_window = (rec_upd.msg_cnt >= window_i);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      BK_IDLE: begin
        if (cmd_valid_i) state_d = BK_EXEC;
      end
      BK_EXEC: begin
        if (cmd_q.op == OP_REPORT || (cmd_q.op == OP_UPDATE && hit_window)) begin
          state_d = BK_REPORT;
        end else if (!res_full) begin
          state_d = BK_IDLE;
        end
      end
      BK_REPORT: begin
        if (!res_full && word_q == LAST_WORD) state_d = BK_IDLE;
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cmd_pop_o = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    res_push  = 1'b0;
    valid_set = 1'b0;
    valid_clr = 1'b0;
    rep_load  = 1'b0;
    word_inc  = 1'b0;
    res_item         = '0;
    res_item.conn    = cmd_q.conn;
    res_item.status  = cmd_q.status;
    res_item.last    = 1'b1;
    unique case (state_q)
      BK_IDLE: begin
        cmd_pop_o = cmd_valid_i;
        ram_re    = cmd_valid_i;
      end
      BK_EXEC: begin
        unique case (cmd_q.op)
          OP_REPORT: begin
            rep_load  = 1'b1;
            valid_clr = 1'b1;
          end
          OP_UPDATE: begin
            if (hit_window) begin
              rep_load  = 1'b1;
              valid_clr = 1'b1;
            end else if (!res_full) begin
              ram_we    = 1'b1;
              valid_set = 1'b1;
              res_push  = 1'b1;
            end
          end
          OP_ERROR: begin
            if (!res_full) begin
              ram_we    = 1'b1;
              valid_set = 1'b1;
              res_push  = 1'b1;
            end
          end
          OP_CLEAR: begin
            if (!res_full) begin
              valid_clr = 1'b1;
              res_push  = 1'b1;
            end
          end
          default: res_push = !res_full;
        endcase
      end
      BK_REPORT: begin
        res_push         = !res_full;
        word_inc         = !res_full;
        res_item.status  = ST_OK;
        res_item.is_word = 1'b1;
        res_item.idx     = word_q;
        res_item.last    = (word_q == LAST_WORD);
        if (word_q < FIRST_DLY) begin
          res_item.value = rep_q.err[word_q[2:0]];
        end else if (word_q < FIRST_ALV) begin
          res_item.value = {16'd0, rep_q.dly[3'(word_q - FIRST_DLY)]};
        end else begin
          res_item.value = {16'd0, rep_q.alv[3'(word_q - FIRST_ALV)]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) cmd_q <= cmd_i;
    if (rep_load)  rep_q <= (cmd_q.op == OP_UPDATE) ? rec_upd : rec_cur;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= BK_IDLE;
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
      word_q     <= '0;
    end else begin
      state_q <= state_d;
      if (cmd_pop_o) rd_valid_q <= valid_q[cmd_i.conn];
      if (valid_clr) begin
        valid_q[cmd_q.conn] <= 1'b0;
      end else if (valid_set) begin
        valid_q[cmd_q.conn] <= 1'b1;
      end
      if (rep_load) begin
        word_q <= '0;
      end else if (word_inc) begin
        word_q <= 4'(word_q + 4'd1);
      end
    end
  end

  // Two-entry result queue.
  res_t       r_mem_q [2];
  logic       rwr_q, rrd_q;
  logic [1:0] rcnt_q;
  logic       r_pop;

  assign res_full    = (rcnt_q == 2'd2);
  assign res_empty_o = (rcnt_q == 2'd0);
  assign res_o       = r_mem_q[rrd_q];
  assign r_pop       = res_pop_i && !res_empty_o;

  always_ff @(posedge clk_i) begin
    if (res_push) r_mem_q[rwr_q] <= res_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rwr_q  <= 1'b0;
      rrd_q  <= 1'b0;
      rcnt_q <= 2'd0;
    end else begin
      if (res_push) rwr_q <= !rwr_q;
      if (r_pop)    rrd_q <= !rrd_q;
      rcnt_q <= 2'(rcnt_q + {1'b0, res_push} - {1'b0, r_pop});
    end
  end

  a_word_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_REPORT |-> word_q <= LAST_WORD)
    else $error("report word counter out of range");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full)
    else $error("result queue written while full");

  a_write_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == BK_EXEC)
    else $error("record written outside execute state");

  a_report_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == BK_EXEC && state_d == BK_REPORT) |=> !valid_q[cmd_q.conn])
    else $error("reported connection not cleared");

endmodule

[sim/tb_link_timing_diagnostics_collector.sv]
// Self-checking testbench for the link timing diagnostics collector.
// Walks a directed table, then randomized phases under changing settings, and checks
// every result against a behavioral predictor or a typed status. Depends on ltdc_pkg.
`timescale 1ns / 1ps

module tb_link_timing_diagnostics_collector;
  import ltdc_pkg::*;

  localparam int unsigned SETTLE_CYCLES = 8;       // well past the result latency
  localparam int unsigned HOLD_CYCLES   = 400;     // long result-side stall
  localparam int unsigned CYCLE_LIMIT   = 400000;

  // One request as the sender offers it.
  typedef struct packed {
    action_e           act;
    logic [CONN_W-1:0] conn;
    logic [15:0]       rtd;
    logic [15:0]       alv;
  } diag_req_t;

  // A row of the directed plan is either a request or a register write.
  typedef enum bit {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    diag_req_t   req;
    reg_idx_e    reg_sel;
    logic [15:0] data;
    bit          typed;   // expected status typed in rather than predicted
    status_e     want;
  } plan_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              push = 1'b0;
  logic              full;
  logic [2:0]        action_i = '0;
  logic [CONN_W-1:0] connection_i = '0;
  logic [15:0]       round_trip_delay_i = '0;
  logic [15:0]       alive_time_i = '0;
  logic              empty;
  logic              pop = 1'b0;
  logic [CONN_W-1:0] report_connection_o;
  logic [1:0]        status_o;
  logic              is_report_word_o;
  logic [3:0]        word_index_o;
  logic [31:0]       word_value_o;
  logic              last_o;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [2:0]        cfg_index_i = '0;
  logic [15:0]       cfg_data_i = '0;

  // Predictor copy of the configuration, at its reset values.
  logic [4:0]  cfg_nc = 5'd1;
  logic [15:0] cfg_age = 16'd750;
  logic [15:0] cfg_win = 16'd5000;
  logic [15:0] cfg_edge [EDGE_COUNT] = '{16'd150, 16'd300, 16'd450, 16'd600};

  // Predictor copy of the per-connection records; everything reads zero after reset.
  logic [15:0] msg_cnt  [MAX_CONN] = '{default: '0};
  logic [31:0] err_cnt  [MAX_CONN][ERR_KINDS] = '{default: '{default: '0}};
  logic [15:0] dly_hist [MAX_CONN][BIN_COUNT] = '{default: '{default: '0}};
  logic [15:0] alv_hist [MAX_CONN][BIN_COUNT] = '{default: '{default: '0}};

  res_t      fresh_words [$];      // results of the request being predicted
  res_t      expected_words [$];   // results still owed by the block
  plan_row_t directed_plan [$];

  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  bit          send_steady = 1'b0; // sender offers back to back
  bit          pop_steady = 1'b0;  // receiver takes every result at once
  bit          hold_req = 1'b0;    // asks the receiver for one long stall

  link_timing_diagnostics_collector dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push                (push),
    .full                (full),
    .action_i            (action_i),
    .connection_i        (connection_i),
    .round_trip_delay_i  (round_trip_delay_i),
    .alive_time_i        (alive_time_i),
    .empty               (empty),
    .pop                 (pop),
    .report_connection_o (report_connection_o),
    .status_o            (status_o),
    .is_report_word_o    (is_report_word_o),
    .word_index_o        (word_index_o),
    .word_value_o        (word_value_o),
    .last_o              (last_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Hard stop in case a handshake never completes.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_words.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatch_count++;
    $display("%0t ns: %s mismatch, got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // The edges must start above zero, rise strictly and stay below t_max.
  function automatic bit edges_ordered();
    if (cfg_edge[0] == 16'd0) return 1'b0;
    for (int i = 0; i + 1 < EDGE_COUNT; i++)
      if (cfg_edge[i] >= cfg_edge[i+1]) return 1'b0;
    return cfg_edge[EDGE_COUNT-1] < cfg_age;
  endfunction

  // Edges are inclusive upper bounds; anything above the last lands in bin five.
  function automatic int bin_for(input logic [15:0] t);
    for (int i = 0; i < EDGE_COUNT; i++)
      if (t <= cfg_edge[i]) return i;
    return EDGE_COUNT;
  endfunction

  function automatic res_t status_word(input logic [CONN_W-1:0] conn, input status_e st);
    res_t r;
    r.conn    = conn;
    r.status  = st;
    r.is_word = 1'b0;
    r.idx     = '0;
    r.value   = '0;
    r.last    = 1'b1;
    return r;
  endfunction

  function automatic void wipe_connection(input int c);
    msg_cnt[c] = '0;
    for (int k = 0; k < ERR_KINDS; k++) err_cnt[c][k] = '0;
    for (int k = 0; k < BIN_COUNT; k++) begin
      dly_hist[c][k] = '0;
      alv_hist[c][k] = '0;
    end
  endfunction

  // Fifteen words in index order: error counters, delay bins, alive bins.
  function automatic void emit_diagnostics(input int c);
    res_t r;
    for (int w = 0; w < REPORT_WORDS; w++) begin
      r.conn    = CONN_W'(c);
      r.status  = ST_OK;
      r.is_word = 1'b1;
      r.idx     = 4'(w);
      if (w < ERR_KINDS) r.value = err_cnt[c][w];
      else if (w < ERR_KINDS + BIN_COUNT) r.value = 32'(dly_hist[c][w - ERR_KINDS]);
      else r.value = 32'(alv_hist[c][w - ERR_KINDS - BIN_COUNT]);
      r.last    = (w == REPORT_WORDS - 1);
      fresh_words.push_back(r);
    end
    wipe_connection(c);
  endfunction

  function automatic void predict_request(input diag_req_t q);
    int c;
    int db;
    int ab;
    c = int'(q.conn);
    fresh_words.delete();
    // The connection check comes first and applies to every action.
    if (5'(q.conn) >= cfg_nc) begin
      fresh_words.push_back(status_word(q.conn, ST_BAD_CONN));
      return;
    end
    case (q.act)
      ACT_TIMING: begin
        // Edge validity is checked before the times themselves.
        if (!edges_ordered()) begin
          fresh_words.push_back(status_word(q.conn, ST_BAD_EDGES));
          return;
        end
        if (q.rtd > cfg_age || q.alv > cfg_age) begin
          fresh_words.push_back(status_word(q.conn, ST_LATE));
          return;
        end
        db = bin_for(q.rtd);
        ab = bin_for(q.alv);
        if (dly_hist[c][db] != 16'hFFFF) dly_hist[c][db]++;
        if (alv_hist[c][ab] != 16'hFFFF) alv_hist[c][ab]++;
        if (msg_cnt[c] != 16'hFFFF) msg_cnt[c]++;
        if (msg_cnt[c] >= cfg_win) begin
          emit_diagnostics(c);
          return;
        end
      end
      ACT_SEND: begin
        emit_diagnostics(c);
        return;
      end
      ACT_CLEAR: wipe_connection(c);
      default: begin
        if (err_cnt[c][int'(q.act) - 1] != 32'hFFFF_FFFF) err_cnt[c][int'(q.act) - 1]++;
      end
    endcase
    fresh_words.push_back(status_word(q.conn, ST_OK));
  endfunction

  function automatic void apply_register(input reg_idx_e idx, input logic [15:0] data);
    case (idx)
      REG_NUM_CONN: cfg_nc = data[4:0];
      REG_MAX_AGE:  cfg_age = data;
      REG_WINDOW:   cfg_win = data;
      REG_EDGE_1:   cfg_edge[0] = data;
      REG_EDGE_2:   cfg_edge[1] = data;
      REG_EDGE_3:   cfg_edge[2] = data;
      REG_EDGE_4:   cfg_edge[3] = data;
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Offers one request and records what it must produce once it is taken.
  // Push stays high when the next request follows without a gap, so push is
  // only lowered at the start of a nonzero gap.
  task automatic send_req(input diag_req_t q, input bit typed, input status_e want);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push               <= 1'b1;
    action_i           <= q.act;
    connection_i       <= q.conn;
    round_trip_delay_i <= q.rtd;
    alive_time_i       <= q.alv;
    do @(posedge clk_i); while (full !== 1'b0);
    predict_request(q);
    if (typed) expected_words.push_back(status_word(q.conn, want));
    else foreach (fresh_words[k]) expected_words.push_back(fresh_words[k]);
  endtask

  // Leaves cfg_valid_i high; the caller lowers it after the last write in a row.
  task automatic write_register(input reg_idx_e idx, input logic [15:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    apply_register(idx, data);
  endtask

  // Stops offering requests and waits until every owed result has come back.
  task automatic wait_idle();
    push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input int nc, input int age, input int win, input int e1,
                            input int e2, input int e3, input int e4);
    wait_idle();
    write_register(REG_NUM_CONN, 16'(nc));
    write_register(REG_MAX_AGE, 16'(age));
    write_register(REG_WINDOW, 16'(win));
    write_register(REG_EDGE_1, 16'(e1));
    write_register(REG_EDGE_2, 16'(e2));
    write_register(REG_EDGE_3, 16'(e3));
    write_register(REG_EDGE_4, 16'(e4));
    cfg_valid_i <= 1'b0;
  endtask

  // Mostly well-formed traffic: connections in use and times within t_max,
  // with a share of out-of-range connections and late times mixed in.
  function automatic diag_req_t random_req(input int send_pct);
    diag_req_t q;
    int p;
    int hi;
    p = $urandom_range(0, 99);
    if (p < send_pct) q.act = ACT_SEND;
    else if (p < send_pct + 4) q.act = ACT_CLEAR;
    else if (p < 60) q.act = ACT_TIMING;
    else q.act = action_e'($urandom_range(int'(ACT_SAFETY), int'(ACT_CSN)));
    hi = (cfg_nc >= MAX_CONN) ? MAX_CONN - 1 : int'(cfg_nc) - 1;
    if (hi >= 0 && $urandom_range(0, 99) < 90) q.conn = CONN_W'($urandom_range(0, hi));
    else q.conn = CONN_W'($urandom_range(0, MAX_CONN - 1));
    if ($urandom_range(0, 99) < 88) q.rtd = 16'($urandom_range(0, int'(cfg_age)));
    else q.rtd = 16'($urandom_range(0, 16'hFFFF));
    if ($urandom_range(0, 99) < 88) q.alv = 16'($urandom_range(0, int'(cfg_age)));
    else q.alv = 16'($urandom_range(0, 16'hFFFF));
    return q;
  endfunction

  task automatic run_phase(input int count, input int send_pct);
    for (int n = 0; n < count; n++) send_req(random_req(send_pct), 1'b0, ST_OK);
  endtask

  function automatic plan_row_t req_row(input action_e act, input int conn, input int rtd,
                                        input int alv, input bit typed, input status_e want);
    plan_row_t r;
    r.kind    = ROW_REQ;
    r.req     = '{act, CONN_W'(conn), 16'(rtd), 16'(alv)};
    r.reg_sel = REG_NUM_CONN;
    r.data    = '0;
    r.typed   = typed;
    r.want    = want;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input reg_idx_e idx, input int data);
    plan_row_t r;
    r.kind    = ROW_CFG;
    r.req     = '{ACT_TIMING, '0, '0, '0};
    r.reg_sel = idx;
    r.data    = 16'(data);
    r.typed   = 1'b0;
    r.want    = ST_OK;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  task automatic check_result();
    res_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("unexpected result, connection", 32'(report_connection_o), 32'd0);
      return;
    end
    want = expected_words.pop_front();
    if (report_connection_o !== want.conn)
      report_mismatch("report_connection", 32'(report_connection_o), 32'(want.conn));
    if (status_o !== want.status)
      report_mismatch("status", 32'(status_o), 32'(want.status));
    if (is_report_word_o !== want.is_word)
      report_mismatch("is_report_word", 32'(is_report_word_o), 32'(want.is_word));
    if (word_index_o !== want.idx)
      report_mismatch("word_index", 32'(word_index_o), 32'(want.idx));
    if (word_value_o !== want.value)
      report_mismatch("word_value", word_value_o, want.value);
    if (last_o !== want.last)
      report_mismatch("last", 32'(last_o), 32'(want.last));
  endtask

  // The receiver draws its own wait before each result. Like push, pop is only
  // lowered when a nonzero wait starts, never in the step it is raised again.
  initial begin
    int gap;
    wait (rst_ni === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        gap = HOLD_CYCLES;
      end else begin
        gap = pop_steady ? 0 : $urandom_range(0, 13);
      end
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (empty !== 1'b0);
      check_result();
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned age;
    int unsigned step;
    int e1;
    int e2;
    int e3;
    int e4;

    // Directed plan. The defaults after reset give one connection, t_max 750
    // and edges 150/300/450/600; typed rows carry a status that follows
    // directly from those settings, the rest go through the predictor.
    directed_plan = '{
      req_row(ACT_TIMING, 0, 0, 0, 1'b1, ST_OK),
      req_row(ACT_TIMING, 1, 0, 0, 1'b1, ST_BAD_CONN),
      req_row(ACT_TIMING, 0, 751, 0, 1'b1, ST_LATE),
      req_row(ACT_TIMING, 0, 0, 751, 1'b1, ST_LATE),
      req_row(ACT_TIMING, 0, 750, 750, 1'b1, ST_OK),
      req_row(ACT_SAFETY, 0, 0, 0, 1'b1, ST_OK),
      req_row(ACT_ADDR, 0, 0, 0, 1'b1, ST_OK),
      req_row(ACT_TYPE, 0, 0, 0, 1'b1, ST_OK),
      req_row(ACT_SN, 0, 0, 0, 1'b1, ST_OK),
      req_row(ACT_CSN, 0, 0, 0, 1'b1, ST_OK),
      req_row(ACT_TIMING, 0, 150, 151, 1'b1, ST_OK),
      req_row(ACT_SEND, 0, 0, 0, 1'b0, ST_OK),
      req_row(ACT_CLEAR, 0, 0, 0, 1'b1, ST_OK),
      req_row(ACT_SEND, 15, 16'hFFFF, 16'hFFFF, 1'b1, ST_BAD_CONN),
      // All sixteen connections, and a window of two updates.
      cfg_row(REG_NUM_CONN, 16),
      cfg_row(REG_WINDOW, 2),
      req_row(ACT_TIMING, 15, 300, 301, 1'b1, ST_OK),
      req_row(ACT_TIMING, 15, 16'hFFFF, 0, 1'b1, ST_LATE),
      req_row(ACT_TIMING, 15, 450, 600, 1'b0, ST_OK),
      req_row(ACT_ADDR, 15, 0, 0, 1'b1, ST_OK),
      req_row(ACT_CLEAR, 15, 0, 0, 1'b1, ST_OK),
      req_row(ACT_SEND, 15, 0, 0, 1'b0, ST_OK),
      // Invalid thresholds: first edge zero, edges not rising, last edge at t_max.
      cfg_row(REG_EDGE_1, 0),
      req_row(ACT_TIMING, 3, 0, 0, 1'b1, ST_BAD_EDGES),
      cfg_row(REG_EDGE_1, 300),
      req_row(ACT_TIMING, 3, 0, 0, 1'b1, ST_BAD_EDGES),
      cfg_row(REG_EDGE_1, 150),
      cfg_row(REG_MAX_AGE, 600),
      req_row(ACT_TIMING, 3, 700, 0, 1'b1, ST_BAD_EDGES),
      // The connection check wins over the threshold check.
      cfg_row(REG_NUM_CONN, 4),
      req_row(ACT_TIMING, 4, 0, 0, 1'b1, ST_BAD_CONN),
      // A window of zero reports on every accepted update.
      cfg_row(REG_MAX_AGE, 16'hFFFF),
      cfg_row(REG_WINDOW, 0),
      req_row(ACT_TIMING, 2, 16'hFFFF, 16'hFFFF, 1'b0, ST_OK),
      req_row(ACT_TIMING, 2, 0, 0, 1'b0, ST_OK)
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        if (i == 0 || directed_plan[i-1].kind != ROW_CFG) wait_idle();
        write_register(directed_plan[i].reg_sel, directed_plan[i].data);
        if (i == directed_plan.size() - 1 || directed_plan[i+1].kind != ROW_CFG)
          cfg_valid_i <= 1'b0;
      end else begin
        send_req(directed_plan[i].req, directed_plan[i].typed, directed_plan[i].want);
      end
    end

    // Default edges with a short window, so reports come often.
    set_config(16, 750, 3, 150, 300, 450, 600);
    run_phase(40, 6);

    // One connection, widest t_max and edges, a report on every update.
    set_config(1, 16'hFFFF, 1, 1, 2, 3, 16'hFFFE);
    run_phase(30, 6);

    // A t_max of one can never hold valid edges; only error counters move.
    set_config(16, 1, 16'hFFFF, 0, 0, 0, 0);
    run_phase(15, 6);

    // Both sides at full rate.
    set_config(8, 1000, 4, 100, 200, 400, 800);
    send_steady = 1'b1;
    pop_steady  = 1'b1;
    run_phase(40, 6);
    send_steady = 1'b0;
    pop_steady  = 1'b0;

    // Random edges, now and then left invalid. The receiver stalls for a long
    // stretch while report-heavy requests arrive back to back, so the result
    // queue fills and the block has to hold off the sender.
    age  = $urandom_range(20, 16'hFFFF);
    step = age / 5;
    e1   = $urandom_range(1, step);
    e2   = e1 + $urandom_range(1, step);
    e3   = e2 + $urandom_range(1, step);
    e4   = e3 + $urandom_range(1, step);
    if ($urandom_range(0, 3) == 0) e3 = e2;
    set_config(16, age, 2, e1, e2, e3, e4);
    hold_req    = 1'b1;
    send_steady = 1'b1;
    run_phase(40, 60);
    send_steady = 1'b0;

    set_config(16, 750, 5, 150, 300, 450, 600);
    run_phase(39, 8);

    wait_idle();
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
